[sv/cts_pkg.sv]
// ============================================================================
// cts_pkg: shared types, constants and functions of the character tone
// synthesizer. Holds reset values, register and operation codes, the tone
// step mapping and the quarter-wave sine ROM generator.
// ============================================================================
package cts_pkg;

    // Default structural parameters
    localparam int unsigned PHASE_BITS_DEF      = 32;
    localparam int unsigned SINE_TABLE_LOG2_DEF = 10;

    // Field widths
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CODE_W     = 8;
    localparam int unsigned STEP_W     = 7;
    localparam int unsigned AMP_W      = 15;
    localparam int unsigned SPS_W      = 16;
    localparam int unsigned SAMPLE_W   = 16;
    localparam int unsigned ROM_W      = 16;

    // Register reset values
    localparam logic [AMP_W-1:0]      AMPLITUDE_RST = 15'd32000;
    localparam logic [SPS_W-1:0]      SPS_RST       = 16'd1024;
    localparam logic [CFG_DATA_W-1:0] BASE_INC_RST  = 32'd29217466;
    localparam logic [CFG_DATA_W-1:0] STEP_INC_RST  = 32'd9639776;

    // pi/2 in Q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AMPLITUDE   = 2'd0,
        CFG_SPS         = 2'd1,
        CFG_BASE_INC    = 2'd2,
        CFG_STEP_INC    = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_TICK = 1'b1
    } t_op;

    // Per-tick control that travels alongside the ROM read
    typedef struct packed {
        logic valid;
        logic active;
        logic last;
        logic neg;
    } t_tick;

    // Map a character code to its tone step; unmapped codes take step 0.
    function automatic logic [STEP_W-1:0] tone_step(input logic [CODE_W-1:0] code);
        logic [STEP_W-1:0] step;
        step = '0;
        if (code == 8'd10) begin
            step = 7'd1;
        end else if (code == 8'd11) begin
            step = 7'd2;
        end else if (code >= 8'd32 && code <= 8'd127) begin
            step = STEP_W'(code - 8'd29);
        end
        return step;
    endfunction

    // Q1.15 quarter-wave entry, built from a Q30 series at elaboration.
    function automatic logic [ROM_W-1:0] rom_entry(input int unsigned idx,
                                                   input int unsigned log2);
        logic [63:0] odd;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        odd  = (64'(idx) << 1) + 64'd1;
        x    = (HALF_PI_Q30 * odd) >> (log2 + 1);
        x2   = (x * x) >> 30;
        term = Q30_ONE;
        term = Q30_ONE - ((x2 * term) >> 30) / 64'd156;
        term = Q30_ONE - ((x2 * term) >> 30) / 64'd110;
        term = Q30_ONE - ((x2 * term) >> 30) / 64'd72;
        term = Q30_ONE - ((x2 * term) >> 30) / 64'd42;
        term = Q30_ONE - ((x2 * term) >> 30) / 64'd20;
        term = Q30_ONE - ((x2 * term) >> 30) / 64'd6;
        return ROM_W'(((((x * term) >> 30) * 64'd32767) + (Q30_ONE >> 1)) >> 30);
    endfunction

endpackage

[sv/cts_in_if.sv]
// ============================================================================
// cts_in_if: input channel of the character tone synthesizer
// Valid/ready channel that carries one load or tick item.
// ============================================================================
interface cts_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] char_code;

    modport source (output valid, output op, output char_code, input ready);
    modport sink   (input valid, input op, input char_code, output ready);
endinterface

[sv/cts_out_if.sv]
// ============================================================================
// cts_out_if: result channel of the character tone synthesizer
// Valid/ready channel that carries one audio sample item.
// ============================================================================
interface cts_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic               active;
    logic               last_of_symbol;

    modport source (output valid, output sample, output active, output last_of_symbol,
                    input ready);
    modport sink   (input valid, input sample, input active, input last_of_symbol,
                    output ready);
endinterface

[sv/cts_tone_ctrl.sv]
// ============================================================================
// cts_tone_ctrl: tone state and phase accumulator
// Loads tone increments, advances the phase per tick and forms the ROM address.
// ============================================================================
module cts_tone_ctrl #(
    parameter int unsigned PHASE_BITS      = cts_pkg::PHASE_BITS_DEF,
    parameter int unsigned SINE_TABLE_LOG2 = cts_pkg::SINE_TABLE_LOG2_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  logic                             i_op,
    input  logic [cts_pkg::CODE_W-1:0]       i_char_code,
    input  logic [cts_pkg::SPS_W-1:0]        i_samples_per_symbol,
    input  logic [cts_pkg::CFG_DATA_W-1:0]   i_base_increment,
    input  logic [cts_pkg::CFG_DATA_W-1:0]   i_step_increment,
    output cts_pkg::t_tick                   o_tick,
    output logic [SINE_TABLE_LOG2-1:0]       o_rom_addr
);
    import cts_pkg::*;

    logic [PHASE_BITS-1:0]      r_phase, n_phase;
    logic [PHASE_BITS-1:0]      r_inc, n_inc;
    logic [SPS_W-1:0]           r_left, n_left;
    logic                       r_active, n_active;

    logic [PHASE_BITS-1:0]      base_p;
    logic [PHASE_BITS-1:0]      step_p;
    logic [PHASE_BITS-1:0]      load_inc;
    logic [PHASE_BITS-1:0]      sum_phase;
    logic [STEP_W-1:0]          step_code;
    logic [SINE_TABLE_LOG2-1:0] idx;
    logic                       is_tick;
    logic                       at_last;

    always_comb begin
        base_p    = PHASE_BITS'(i_base_increment);
        step_p    = PHASE_BITS'(i_step_increment);
        step_code = tone_step(i_char_code);
        load_inc  = base_p + PHASE_BITS'(step_p * PHASE_BITS'(step_code));
        sum_phase = r_phase + r_inc;
        is_tick   = (i_op == OP_TICK);
        at_last   = (r_left == SPS_W'(1));

        n_phase  = r_phase;
        n_inc    = r_inc;
        n_left   = r_left;
        n_active = r_active;
        if (i_accept) begin
            if (!is_tick) begin
                n_inc    = load_inc;
                n_phase  = '0;
                n_left   = i_samples_per_symbol;
                n_active = (i_samples_per_symbol != '0);
            end else if (r_active) begin
                n_phase = sum_phase;
                n_left  = r_left - SPS_W'(1);
                if (at_last) begin
                    n_active = 1'b0;
                end
            end
        end

        // odd quadrants read the table backward
        idx        = sum_phase[PHASE_BITS-3 -: SINE_TABLE_LOG2];
        o_rom_addr = sum_phase[PHASE_BITS-2] ? ~idx : idx;

        o_tick.valid  = i_accept && is_tick;
        o_tick.active = r_active;
        o_tick.last   = r_active && at_last;
        o_tick.neg    = sum_phase[PHASE_BITS-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= '0;
            r_inc    <= '0;
            r_left   <= '0;
            r_active <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_inc    <= n_inc;
            r_left   <= n_left;
            r_active <= n_active;
        end
    end

endmodule

[sv/cts_sine_rom.sv]
// ============================================================================
// cts_sine_rom: quarter-wave sine ROM
// Constant Q1.15 table with a registered read port.
// ============================================================================
module cts_sine_rom #(
    parameter int unsigned SINE_TABLE_LOG2 = cts_pkg::SINE_TABLE_LOG2_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [SINE_TABLE_LOG2-1:0]  i_addr,
    output logic [cts_pkg::ROM_W-1:0]   o_data
);
    import cts_pkg::*;

    localparam int unsigned DEPTH = 1 << SINE_TABLE_LOG2;

    logic [ROM_W-1:0] rom_tbl [DEPTH];
    logic [ROM_W-1:0] r_data;

    for (genvar g = 0; g < DEPTH; g++) begin : g_rom
        assign rom_tbl[g] = rom_entry(g, SINE_TABLE_LOG2);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= rom_tbl[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

[sv/cts_scale.sv]
// ============================================================================
// cts_scale: amplitude scaling and result register
// Scales the ROM word by the amplitude, applies the sign and holds the result.
// ============================================================================
module cts_scale (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  cts_pkg::t_tick              i_tick,
    input  logic [cts_pkg::ROM_W-1:0]   i_rom_data,
    input  logic [cts_pkg::AMP_W-1:0]   i_amplitude,
    output logic                        o_advance,
    cts_out_if.source                   o_out
);
    import cts_pkg::*;

    localparam int unsigned PROD_W = AMP_W + ROM_W;

    t_tick                 r_s1;
    logic                  r_out_valid;
    logic [SAMPLE_W-1:0]   r_sample;
    logic                  r_active;
    logic                  r_last;

    logic [PROD_W-1:0]     prod;
    logic [SAMPLE_W-1:0]   mag;
    logic [SAMPLE_W-1:0]   n_sample;

    always_comb begin
        o_advance = !r_out_valid || o_out.ready;
        prod      = PROD_W'(i_amplitude) * PROD_W'(i_rom_data);
        mag       = r_s1.active ? prod[PROD_W-1 -: SAMPLE_W] : '0;
        n_sample  = r_s1.neg ? (SAMPLE_W'(0) - mag) : mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (o_advance) begin
            r_s1        <= i_tick;
            r_out_valid <= r_s1.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_sample <= n_sample;
            r_active <= r_s1.active;
            r_last   <= r_s1.last;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.sample         = $signed(r_sample);
    assign o_out.active         = r_active;
    assign o_out.last_of_symbol = r_last;

endmodule

[sv/character_tone_synthesizer.sv]
// ============================================================================
// character_tone_synthesizer: multi-tone DDS character synthesizer
// Maps characters to tones and emits one scaled sine sample per tick item.
// ============================================================================
// Usage:
//   i_in carries items of two kinds. A load item (op 0) sets the tone of
//   char_code, restarts the phase at zero and arms samples_per_symbol ticks;
//   it gives no result. A tick item (op 1) gives exactly one result on
//   o_out: the next sample of the armed tone, or a silent sample (zero,
//   active low) when no symbol is armed. The final sample of a symbol has
//   last_of_symbol high. A load during a symbol drops the rest of it.
//   Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data while
//   the block is idle; amplitude applies from the next tick, the other
//   registers from the next load.
// Timing:
//   One item is accepted per cycle while the pipeline advances. A tick's
//   result reaches o_out through the registers in order: the phase add and
//   the registered sine ROM read land at the accepting edge, the amplitude
//   multiply lands in the result register when the pipeline next advances.
// Reset and stall:
//   Reset restores the register defaults and silences the tone. When the
//   receiver holds o_out.ready low with a result waiting, the whole pipeline
//   holds and i_in.ready drops; nothing is lost or repeated.
// ============================================================================
module character_tone_synthesizer #(
    parameter int unsigned PHASE_BITS      = cts_pkg::PHASE_BITS_DEF,
    parameter int unsigned SINE_TABLE_LOG2 = cts_pkg::SINE_TABLE_LOG2_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [cts_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [cts_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    cts_in_if.sink                           i_in,
    cts_out_if.source                        o_out
);
    import cts_pkg::*;

    // Configuration registers
    logic [AMP_W-1:0]       r_amplitude;
    logic [SPS_W-1:0]       r_sps;
    logic [CFG_DATA_W-1:0]  r_base_inc;
    logic [CFG_DATA_W-1:0]  r_step_inc;

    logic                       w_advance;
    logic                       w_accept;
    t_tick                      w_tick;
    logic [SINE_TABLE_LOG2-1:0] w_rom_addr;
    logic [ROM_W-1:0]           w_rom_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amplitude <= AMPLITUDE_RST;
            r_sps       <= SPS_RST;
            r_base_inc  <= BASE_INC_RST;
            r_step_inc  <= STEP_INC_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_AMPLITUDE: r_amplitude <= i_cfg_data[AMP_W-1:0];
                CFG_SPS:       r_sps       <= i_cfg_data[SPS_W-1:0];
                CFG_BASE_INC:  r_base_inc  <= i_cfg_data;
                CFG_STEP_INC:  r_step_inc  <= i_cfg_data;
                default: begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    // The pipeline advances as a whole whenever the result register is empty or its result is taken.
    assign i_in.ready = w_advance;
    assign w_accept   = i_in.valid && w_advance;

    // Stage 0: tone state, phase add and ROM address
    cts_tone_ctrl #(
        .PHASE_BITS      (PHASE_BITS),
        .SINE_TABLE_LOG2 (SINE_TABLE_LOG2)
    ) u_ctrl (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_accept             (w_accept),
        .i_op                 (i_in.op),
        .i_char_code          (i_in.char_code),
        .i_samples_per_symbol (r_sps),
        .i_base_increment     (r_base_inc),
        .i_step_increment     (r_step_inc),
        .o_tick               (w_tick),
        .o_rom_addr           (w_rom_addr)
    );

    // Stage 1: registered sine lookup
    cts_sine_rom #(
        .SINE_TABLE_LOG2 (SINE_TABLE_LOG2)
    ) u_rom (
        .i_clk  (i_clk),
        .i_en   (w_advance),
        .i_addr (w_rom_addr),
        .o_data (w_rom_data)
    );

    // Stage 2: scale, sign and result register
    cts_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tick      (w_tick),
        .i_rom_data  (w_rom_data),
        .i_amplitude (r_amplitude),
        .o_advance   (w_advance),
        .o_out       (o_out)
    );

endmodule

[tb/tb_character_tone_synthesizer.sv]
// ============================================================================
// tb_character_tone_synthesizer: self-checking bench for the tone synthesizer
// Drives load and tick items through the valid/ready channels and rewrites
// the configuration between phases. A cycle-free tone predictor computes each
// expected sample, and every result item is compared field by field against
// the oldest expected sample. Both channel sides idle and stall at random.
// ============================================================================
module tb_character_tone_synthesizer;
    import cts_pkg::*;

    localparam int unsigned LIMIT_CYCLES = 300000;
    localparam int unsigned DRAIN_CYCLES = 6;
    localparam int unsigned HOLD_CYCLES  = 200;    // long receiver hold-off
    localparam int unsigned ROM_DEPTH    = 1024;
    localparam int unsigned PHASE_ITEMS  = 105;
    localparam int unsigned NUM_PHASES   = 8;
    localparam int unsigned NUM_ROWS     = 24;
    localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;   // pi/2 in Q30
    localparam logic [63:0] ONE_Q30          = 64'd1 << 30;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               active;
        logic               last;
    } t_sample_exp;

    typedef struct {
        t_op         op;
        logic [7:0]  code;
        bit          typed;    // expected sample typed into the row
        t_sample_exp want;
    } t_stim_row;

    localparam t_sample_exp SILENT = '0;

    // Opening rows run with the reset configuration. Only the idle ticks
    // right after reset carry a typed expectation; the rest go through the
    // predictor. Loads follow each other mid-symbol, so each one drops the
    // running tone.
    t_stim_row opening_rows [NUM_ROWS] = '{
        '{OP_TICK, 8'd0,   1'b1, SILENT},   // idle tick after reset
        '{OP_TICK, 8'd255, 1'b1, SILENT},   // idle tick, code ignored
        '{OP_LOAD, 8'd9,   1'b0, SILENT},   // tab: lowest tone
        '{OP_TICK, 8'd0,   1'b0, SILENT},
        '{OP_TICK, 8'd0,   1'b0, SILENT},
        '{OP_TICK, 8'd0,   1'b0, SILENT},
        '{OP_LOAD, 8'd10,  1'b0, SILENT},   // line feed
        '{OP_TICK, 8'd0,   1'b0, SILENT},
        '{OP_LOAD, 8'd11,  1'b0, SILENT},   // vertical tab
        '{OP_TICK, 8'd0,   1'b0, SILENT},
        '{OP_LOAD, 8'd32,  1'b0, SILENT},   // first printable
        '{OP_TICK, 8'd0,   1'b0, SILENT},
        '{OP_LOAD, 8'd127, 1'b0, SILENT},   // top of the printable range
        '{OP_TICK, 8'd0,   1'b0, SILENT},
        '{OP_LOAD, 8'd0,   1'b0, SILENT},   // unmapped codes from here on
        '{OP_TICK, 8'd0,   1'b0, SILENT},
        '{OP_LOAD, 8'd255, 1'b0, SILENT},
        '{OP_TICK, 8'd0,   1'b0, SILENT},
        '{OP_LOAD, 8'd128, 1'b0, SILENT},
        '{OP_TICK, 8'd0,   1'b0, SILENT},
        '{OP_LOAD, 8'd31,  1'b0, SILENT},
        '{OP_TICK, 8'd0,   1'b0, SILENT},
        '{OP_LOAD, 8'd8,   1'b0, SILENT},
        '{OP_TICK, 8'd0,   1'b0, SILENT}
    };

    // Register sets per phase, in register index order. Phase 0 keeps the
    // reset values and writes nothing; phase 5 is drawn at random.
    logic [31:0] phase_regs [NUM_PHASES][4] = '{
        '{32'd32000, 32'd1024,  32'd29217466, 32'd9639776},
        '{32'd32767, 32'd1,     32'd0,        32'd0},          // frozen phase
        '{32'd0,     32'd65535, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, // silent, longest
        '{32'd32767, 32'd3,     32'hFFFF_FFFF, 32'hFFFF_FFFF}, // increment wraps
        '{32'd1,     32'd0,     32'h1234_5678, 32'h1111_1111}, // zero length
        '{32'd0,     32'd0,     32'd0,        32'd0},
        '{32'd20000, 32'd7,     32'h4000_0000, 32'h0100_0000},
        '{32'd32000, 32'd5,     32'd29217466, 32'd9639776}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    t_cfg_idx    i_cfg_idx;
    logic [31:0] i_cfg_data;

    cts_in_if  in_ch ();
    cts_out_if out_ch ();

    character_tone_synthesizer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // Tone predictor: configuration and tone state
    logic [14:0] amp_q;
    logic [15:0] sps_q;
    logic [31:0] base_q;
    logic [31:0] stepinc_q;
    logic [31:0] phase_q;
    logic [31:0] inc_q;
    logic [15:0] left_q;
    logic        armed_q;
    logic [15:0] sine_quarter [ROM_DEPTH];

    t_sample_exp pending_samples [$];
    int          mismatches;
    int unsigned cycles;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    bit          hold_req;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Quarter-wave sine in Q1.15: Taylor series in Q30, evaluated Horner
    // style; the divisors are (2m)(2m+1) for m = 6 down to 1.
    function automatic logic [15:0] quarter_sine(input int unsigned i);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        int          m;
        x  = (QUARTER_TURN_Q30 * (64'(i) * 64'd2 + 64'd1)) / (64'd2 * 64'(ROM_DEPTH));
        x2 = (x * x) >> 30;
        t  = ONE_Q30;
        for (m = 6; m >= 1; m--) begin
            t = ONE_Q30 - ((x2 * t) >> 30) / (64'(2 * m) * 64'(2 * m + 1));
        end
        return 16'(((((x * t) >> 30) * 64'd32767) + (ONE_Q30 >> 1)) >> 30);
    endfunction

    // Tab, LF and VT take the three lowest steps; printables sit above them.
    function automatic logic [6:0] tone_step_of(input logic [7:0] code);
        if (code == 8'd10) begin
            return 7'd1;
        end else if (code == 8'd11) begin
            return 7'd2;
        end else if (code >= 8'd32 && code <= 8'd127) begin
            return 7'(code - 8'd29);
        end
        return 7'd0;
    endfunction

    // Load: pick the increment (wraps at 32 bits), restart the phase, arm.
    function automatic void arm_tone(input logic [7:0] code);
        inc_q   = base_q + 32'(tone_step_of(code)) * stepinc_q;
        phase_q = '0;
        left_q  = sps_q;
        armed_q = (sps_q != 16'd0);
    endfunction

    // Tick: advance the phase, then look up and scale the sine.
    function automatic t_sample_exp advance_tone();
        t_sample_exp s;
        logic [9:0]  idx;
        logic [31:0] mag;
        s = SILENT;
        if (!armed_q) begin
            return s;
        end
        phase_q = phase_q + inc_q;
        idx     = phase_q[29:20];
        if (phase_q[30]) begin
            idx = ~idx;    // odd quadrants read the table backward
        end
        mag      = (32'(amp_q) * 32'(sine_quarter[idx])) >> 15;
        s.sample = phase_q[31] ? 16'(32'd0 - mag) : 16'(mag);
        s.active = 1'b1;
        left_q   = left_q - 16'd1;
        s.last   = (left_q == 16'd0);
        if (s.last) begin
            armed_q = 1'b0;
        end
        return s;
    endfunction

    // Offer one item, with random gaps ahead of it, and hold it until taken.
    // Valid stays high after acceptance so back-to-back items need no toggle.
    task automatic send_item(input t_op op, input logic [7:0] code, input bit typed,
                             input t_sample_exp want);
        t_sample_exp s;
        if ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            do begin
                @(posedge i_clk);
            end while ($urandom_range(99) < send_idle_pct);
        end
        in_ch.valid     <= 1'b1;
        in_ch.op        <= op;
        in_ch.char_code <= code;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        if (op == OP_LOAD) begin
            arm_tone(code);
        end else begin
            s = advance_tone();
            pending_samples.push_back(typed ? want : s);
        end
    endtask

    // Hold until every expected sample is in, then let the pipeline settle.
    task automatic wait_drained();
        while (pending_samples.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Receiver: check each result item, then pick the next ready. A hold
    // request from the stimulus drops ready for a long counted stretch.
    initial begin : receiver
        int unsigned hold_left;
        t_sample_exp want;
        hold_left    = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                if (pending_samples.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result: expected none, got sample %0d active %0b last %0b",
                             $time, out_ch.sample, out_ch.active, out_ch.last_of_symbol);
                end else begin
                    want = pending_samples.pop_front();
                    if (out_ch.sample !== want.sample) begin
                        mismatches++;
                        $display("%0t: sample mismatch: expected %0d, got %0d",
                                 $time, want.sample, out_ch.sample);
                    end
                    if (out_ch.active !== want.active) begin
                        mismatches++;
                        $display("%0t: active mismatch: expected %0b, got %0b",
                                 $time, want.active, out_ch.active);
                    end
                    if (out_ch.last_of_symbol !== want.last) begin
                        mismatches++;
                        $display("%0t: last_of_symbol mismatch: expected %0b, got %0b",
                                 $time, want.last, out_ch.last_of_symbol);
                    end
                end
            end
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else if (hold_req) begin
                hold_req     = 1'b0;
                hold_left    = HOLD_CYCLES - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: fail the run once it exceeds the cycle limit.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned p;
        int unsigned r;
        int unsigned k;
        int unsigned n_ticks;
        int unsigned phase_items;
        int unsigned hold_at;
        int unsigned pause_at;
        bit          held;
        bit          paused;
        logic [7:0]  code;

        // Drive every input to a known value before the first edge
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = CFG_AMPLITUDE;
        i_cfg_data      = '0;
        in_ch.valid     = 1'b0;
        in_ch.op        = OP_TICK;
        in_ch.char_code = '0;
        mismatches      = 0;
        cycles          = 0;
        hold_req        = 1'b0;
        send_idle_pct   = 25;
        recv_idle_pct   = 57;

        for (r = 0; r < ROM_DEPTH; r++) begin
            sine_quarter[r] = quarter_sine(r);
        end
        amp_q     = 15'd32000;
        sps_q     = 16'd1024;
        base_q    = 32'd29217466;
        stepinc_q = 32'd9639776;
        phase_q   = '0;
        inc_q     = '0;
        left_q    = '0;
        armed_q   = 1'b0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (r = 0; r < NUM_ROWS; r++) begin
            send_item(opening_rows[r].op, opening_rows[r].code, opening_rows[r].typed,
                      opening_rows[r].want);
        end

        for (p = 0; p < NUM_PHASES; p++) begin
            // Receiver idles more first, then the sender, then nobody
            if (p < 3) begin
                send_idle_pct = 25;
                recv_idle_pct = 57;
            end else if (p < 6) begin
                send_idle_pct = 57;
                recv_idle_pct = 25;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            if (p > 0) begin
                if (p == 5) begin
                    phase_regs[p][CFG_AMPLITUDE] = $urandom_range(32767);
                    phase_regs[p][CFG_SPS]       = $urandom_range(24, 2);
                    phase_regs[p][CFG_BASE_INC]  = $urandom();
                    phase_regs[p][CFG_STEP_INC]  = $urandom();
                end
                // Write registers only with the block idle
                in_ch.valid <= 1'b0;
                wait_drained();
                for (k = 0; k < 4; k++) begin
                    i_cfg_we   <= 1'b1;
                    i_cfg_idx  <= t_cfg_idx'(k);
                    i_cfg_data <= phase_regs[p][k];
                    @(posedge i_clk);
                end
                i_cfg_we  <= 1'b0;
                amp_q     = phase_regs[p][CFG_AMPLITUDE][14:0];
                sps_q     = phase_regs[p][CFG_SPS][15:0];
                base_q    = phase_regs[p][CFG_BASE_INC];
                stepinc_q = phase_regs[p][CFG_STEP_INC];
            end

            // Receiver hold-off in two phases, one sender pause in another
            held        = !(p == 2 || p == 6);
            paused      = (p != 3);
            hold_at     = PHASE_ITEMS / 3;
            pause_at    = PHASE_ITEMS / 2;
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                if (!held && phase_items >= hold_at) begin
                    held     = 1'b1;
                    hold_req = 1'b1;
                end
                if (!paused && phase_items >= pause_at) begin
                    paused = 1'b1;
                    in_ch.valid <= 1'b0;
                    wait_drained();
                end
                // Mostly whole symbols; a load always opens the phase
                if (phase_items == 0 || $urandom_range(99) >= 12) begin
                    k = $urandom_range(99);
                    if (k < 50) begin
                        code = 8'($urandom_range(127, 32));
                    end else if (k < 65) begin
                        code = 8'($urandom_range(11, 9));
                    end else begin
                        code = 8'($urandom_range(255));
                    end
                    send_item(OP_LOAD, code, 1'b0, SILENT);
                    phase_items++;
                    if (sps_q == 16'd0) begin
                        n_ticks = $urandom_range(4, 1);
                    end else if (sps_q > 16'd40) begin
                        n_ticks = $urandom_range(40, 1);
                    end else begin
                        // Full symbol, cut short, or run on into idle ticks
                        k = $urandom_range(99);
                        if (k < 60) begin
                            n_ticks = sps_q;
                        end else if (k < 80) begin
                            n_ticks = $urandom_range(sps_q, 1);
                        end else begin
                            n_ticks = sps_q + $urandom_range(3, 1);
                        end
                    end
                    for (k = 0; k < n_ticks; k++) begin
                        send_item(OP_TICK, 8'($urandom_range(255)), 1'b0, SILENT);
                        phase_items++;
                    end
                end else begin
                    send_item(t_op'($urandom_range(1)), 8'($urandom_range(255)), 1'b0,
                              SILENT);
                    phase_items++;
                end
            end
        end

        in_ch.valid <= 1'b0;
        wait_drained();
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
